FILE: rtl/lru_block_cache_with_pinning_defines.svh
// ----------------------------------------------------------------------------
// lru_block_cache_with_pinning_defines
// assertion macros for the block cache, empty when SYNTH is set
// ----------------------------------------------------------------------------
`ifndef LRU_BLOCK_CACHE_WITH_PINNING_DEFINES_SVH
`define LRU_BLOCK_CACHE_WITH_PINNING_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication
`define LBC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define LBC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define LBC_ASSERT_IMP(lbl, ante, cons)

`define LBC_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

FILE: rtl/lbc_pkg.sv
// ----------------------------------------------------------------------------
// lbc_pkg
// types, codes and helpers shared by the block cache modules
// ----------------------------------------------------------------------------
package lbc_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // operation codes
  localparam logic [1:0] OP_ACQUIRE = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_PIN     = 2'd2;
  localparam logic [1:0] OP_UNPIN   = 2'd3;

  // status codes
  localparam logic [2:0] ST_HIT      = 3'd0;
  localparam logic [2:0] ST_MISS     = 3'd1;
  localparam logic [2:0] ST_BUSY     = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_DONE     = 3'd5;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] blk_num;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot;
    logic        needs_read;
    logic        evicted;
    logic [31:0] evicted_blk_num;
    logic [4:0]  cached_count;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_UPDATE
  } lbc_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_item;
    logic lookup;
    logic commit;
  } lbc_cmd_t;

  // index of the lowest set bit, zero when none is set
  function automatic logic [IDX_W-1:0] first_set(input logic [CAPACITY-1:0] vec);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (vec[i]) begin
        idx = IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

FILE: rtl/lbc_ctrl.sv
// ----------------------------------------------------------------------------
// lbc_ctrl
// sequencer for lookup and update, plus the result valid flag
// ----------------------------------------------------------------------------
module lbc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output lbc_pkg::lbc_cmd_t cmd
);
  import lbc_pkg::*;

  lbc_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       commit;
  logic       accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    commit    = 1'b0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        // commit only when the result register is free this cycle
        commit   = !out_valid_r || out_ready;
        in_ready = commit;
        if (commit) begin
          state_nxt = in_valid ? S_LOOKUP : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    accept = in_valid && in_ready;

    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end

    cmd.load_item = accept;
    cmd.lookup    = (state_r == S_LOOKUP);
    cmd.commit    = commit;
  end

  assign out_valid = out_valid_r;

endmodule

FILE: rtl/lbc_datapath.sv
// ----------------------------------------------------------------------------
// lbc_datapath
// tag table, marks, recency ranks, lookup and update logic, result register
// ----------------------------------------------------------------------------
module lbc_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  lbc_pkg::lbc_cmd_t  cmd,
  input  lbc_pkg::in_item_t  in_data,
  output lbc_pkg::out_item_t out_data
);
  import lbc_pkg::*;

  // table state
  logic [31:0]         tag_r    [CAPACITY];
  logic [IDX_W-1:0]    rank_r   [CAPACITY];
  logic [IDX_W-1:0]    rank_nxt [CAPACITY];
  logic [CAPACITY-1:0] valid_r, valid_nxt;
  logic [CAPACITY-1:0] held_r, held_nxt;
  logic [CAPACITY-1:0] pinned_r, pinned_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;

  in_item_t  item_r;
  out_item_t out_r, out_nxt;

  // lookup results
  logic             hit_r;
  logic [IDX_W-1:0] hit_idx_r;
  logic             fill_r;
  logic             evict_r;
  logic [IDX_W-1:0] tgt_r;
  logic [CNT_W-1:0] thr_r;
  logic [31:0]      ev_tag_r;

  // lookup logic
  logic [CAPACITY-1:0] hit_vec, cand_vec, vic_vec;
  logic [IDX_W-1:0]    hit_idx, free_idx, vic_idx;
  logic                free_any;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      hit_vec[i]  = valid_r[i] && (tag_r[i] == item_r.blk_num);
      cand_vec[i] = valid_r[i] && !held_r[i] && !pinned_r[i];
    end
    // victim: a candidate with no candidate of higher rank
    for (int i = 0; i < CAPACITY; i++) begin
      vic_vec[i] = cand_vec[i];
      for (int j = 0; j < CAPACITY; j++) begin
        if (cand_vec[j] && (rank_r[j] > rank_r[i])) begin
          vic_vec[i] = 1'b0;
        end
      end
    end
    hit_idx  = first_set(hit_vec);
    free_idx = first_set(~valid_r);
    vic_idx  = first_set(vic_vec);
    free_any = count_r < CNT_W'(CAPACITY);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_data;
    end
    if (cmd.lookup) begin
      hit_r     <= |hit_vec;
      hit_idx_r <= hit_idx;
      fill_r    <= free_any || (|cand_vec);
      evict_r   <= !free_any && (|cand_vec);
      tgt_r     <= free_any ? free_idx : vic_idx;
      ev_tag_r  <= tag_r[vic_idx];
      if (|hit_vec) begin
        thr_r <= CNT_W'(rank_r[hit_idx]);
      end else if (free_any) begin
        thr_r <= CNT_W'(CAPACITY);
      end else begin
        thr_r <= CNT_W'(rank_r[vic_idx]);
      end
    end
  end

  // update logic
  logic             is_acq, touch, fill_now, age;
  logic [IDX_W-1:0] upd_idx;

  always_comb begin
    is_acq   = (item_r.operation == OP_ACQUIRE);
    touch    = is_acq && hit_r && !held_r[hit_idx_r];
    fill_now = is_acq && !hit_r && fill_r;
    age      = touch || fill_now;
    upd_idx  = touch ? hit_idx_r : tgt_r;

    valid_nxt  = valid_r;
    held_nxt   = held_r;
    pinned_nxt = pinned_r;
    count_nxt  = count_r;
    for (int i = 0; i < CAPACITY; i++) begin
      rank_nxt[i] = rank_r[i];
      if (age && valid_r[i] && (IDX_W'(i) != upd_idx) &&
          (CNT_W'(rank_r[i]) < thr_r)) begin
        rank_nxt[i] = rank_r[i] + IDX_W'(1);
      end
    end

    out_nxt.status          = ST_DONE;
    out_nxt.slot            = '0;
    out_nxt.needs_read      = fill_now;
    out_nxt.evicted         = fill_now && evict_r;
    out_nxt.evicted_blk_num = (fill_now && evict_r) ? ev_tag_r : 32'd0;

    if (age) begin
      rank_nxt[upd_idx] = '0;
      held_nxt[upd_idx] = 1'b1;
    end
    if (fill_now) begin
      valid_nxt[upd_idx]  = 1'b1;
      pinned_nxt[upd_idx] = 1'b0;
      if (!evict_r) begin
        count_nxt = count_r + CNT_W'(1);
      end
    end

    if (is_acq) begin
      if (hit_r) begin
        out_nxt.slot   = 4'(hit_idx_r);
        out_nxt.status = touch ? ST_HIT : ST_BUSY;
      end else if (fill_r) begin
        out_nxt.slot   = 4'(tgt_r);
        out_nxt.status = ST_MISS;
      end else begin
        out_nxt.status = ST_FULL;
      end
    end else if (!hit_r) begin
      out_nxt.status = ST_NOTFOUND;
    end else begin
      out_nxt.slot = 4'(hit_idx_r);
      case (item_r.operation)
        OP_RELEASE: held_nxt[hit_idx_r]   = 1'b0;
        OP_PIN:     pinned_nxt[hit_idx_r] = 1'b1;
        OP_UNPIN:   pinned_nxt[hit_idx_r] = 1'b0;
        default:    held_nxt[hit_idx_r]   = held_r[hit_idx_r];
      endcase
    end
    out_nxt.cached_count = 5'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      held_r   <= '0;
      pinned_r <= '0;
      count_r  <= '0;
      for (int i = 0; i < CAPACITY; i++) begin
        rank_r[i] <= '0;
      end
    end else if (cmd.commit) begin
      valid_r  <= valid_nxt;
      held_r   <= held_nxt;
      pinned_r <= pinned_nxt;
      count_r  <= count_nxt;
      for (int i = 0; i < CAPACITY; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
    end
  end

  // tags and result payload need no reset
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_r <= out_nxt;
      if (fill_now) begin
        tag_r[tgt_r] <= item_r.blk_num;
      end
    end
  end

  assign out_data = out_r;

endmodule

FILE: rtl/lru_block_cache_with_pinning.sv
// ----------------------------------------------------------------------------
// lru_block_cache_with_pinning
// tag and recency bookkeeping for a buffer cache with held and pinned entries
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  in_      input      in_valid / in_ready   in_data  (operation, blk_num)
//  out_     output     out_valid / out_ready out_data (status .. cached_count)
//
//  each item goes through a lookup cycle (parallel tag compare over all
//  sixteen entries and the victim search) and an update cycle (recency ranks,
//  marks, tag write, result register load)
//  a new item is taken in the update cycle of the previous one, so a steady
//  stream alternates lookup and update cycles
//  the update cycle waits while the result register holds an untaken result
//  synchronous active-low reset empties the table at once; no clearing pass
// ----------------------------------------------------------------------------
`include "lru_block_cache_with_pinning_defines.svh"

module lru_block_cache_with_pinning (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lbc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output lbc_pkg::out_item_t out_data
);
  import lbc_pkg::*;

  lbc_cmd_t cmd;

  // sequencer: idle, lookup, update; owns the result valid flag
  lbc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // table state, lookup and update logic, result register
  lbc_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

  // a committed update always leaves a result for transfer
  `LBC_ASSERT_NXT(a_commit_shows, cmd.commit, out_valid)
  // lookup is a single cycle, always followed by update
  `LBC_ASSERT_NXT(a_lookup_once, cmd.lookup, !cmd.lookup)
  // count never passes the table size
  `LBC_ASSERT_IMP(a_count_cap, out_valid, out_data.cached_count <= 5'(CAPACITY))
  // a refused acquire only happens on a full table and reports nothing else
  `LBC_ASSERT_IMP(a_full_clean, out_valid && (out_data.status == ST_FULL),
    (out_data.slot == 4'd0) && !out_data.needs_read &&
    (out_data.cached_count == 5'(CAPACITY)))
  // a device read is asked only by a filled miss
  `LBC_ASSERT_IMP(a_read_miss, out_valid && out_data.needs_read,
    out_data.status == ST_MISS)

endmodule
